// ----- hw/rtl/fspa_pkg.sv -----
package fspa_pkg;

  localparam int SLOTS = 64;
  localparam int PTR_W = $clog2(SLOTS);
  localparam int CNT_W = PTR_W + 1;
  localparam int IDX_W = 7;

  typedef enum logic {
    FUNC_RENT   = 1'b0,
    FUNC_RETURN = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    STAT_GRANTED  = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_RETURNED = 2'd2,
    STAT_REJECTED = 2'd3
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic commit;
  } cmd_t;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(SLOTS - 1)) ? '0 : p + PTR_W'(1);
  endfunction

endpackage

// ----- hw/rtl/fspa_req_if.sv -----
interface fspa_req_if
  import fspa_pkg::*;
();
  logic             valid;
  logic             ready;
  func_e            func;
  logic [IDX_W-1:0] slot_index;

  modport source (output valid, func, slot_index, input ready);
  modport sink   (input valid, func, slot_index, output ready);
endinterface

// ----- hw/rtl/fspa_rsp_if.sv -----
interface fspa_rsp_if
  import fspa_pkg::*;
();
  logic             valid;
  logic             ready;
  status_e          status;
  logic [PTR_W-1:0] granted_slot;
  logic [CNT_W-1:0] free_count;

  modport source (output valid, status, granted_slot, free_count, input ready);
  modport sink   (input valid, status, granted_slot, free_count, output ready);
endinterface

// ----- hw/rtl/fspa_ctrl.sv -----
module fspa_ctrl
  import fspa_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_vld_q, out_vld_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_vld_d   = out_vld_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        // wait for the result register to drain
        if (!out_vld_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          out_vld_d    = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_vld_q;

`ifndef ASSERT_OFF
  a_commit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_vld_q)
    else $error("commit did not load result register");
  a_one_per_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> !cmd_o.capture)
    else $error("second item captured before commit");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_ready_i) |=> out_vld_q)
    else $error("result dropped while stalled");
`endif

endmodule

// ----- hw/rtl/fspa_dp.sv -----
module fspa_dp
  import fspa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  input  func_e            func_i,
  input  logic [IDX_W-1:0] slot_index_i,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_data_i,
  output status_e          status_o,
  output logic [PTR_W-1:0] granted_slot_o,
  output logic [CNT_W-1:0] free_count_o
);

  logic [PTR_W-1:0] ring_q [SLOTS];
  logic [SLOTS-1:0] vld_q;
  logic [PTR_W-1:0] head_q, tail_q;
  logic [CNT_W-1:0] total_q, pool_q;
  func_e            func_q;
  logic [IDX_W-1:0] slot_q;
  logic [PTR_W-1:0] rd_q;
  logic             rd_vld_q;
  status_e          status_q;
  logic [PTR_W-1:0] grant_q;
  logic [CNT_W-1:0] count_q;

  logic [CNT_W-1:0] pool_d;
  logic [PTR_W-1:0] head_slot;
  logic             do_rent, do_return, reject;

  // clamp the written count to 1..SLOTS
  always_comb begin
    priority if (cfg_data_i == '0)               pool_d = CNT_W'(1);
    else if (cfg_data_i > CNT_W'(SLOTS))         pool_d = CNT_W'(SLOTS);
    else                                         pool_d = cfg_data_i;
  end

  // entries never written since refill hold their own index
  assign head_slot = rd_vld_q ? rd_q : head_q;

  assign reject    = (CNT_W'(slot_q) >= pool_q) || (total_q >= pool_q);
  assign do_rent   = cmd_i.commit && (func_q == FUNC_RENT) && (total_q != '0);
  assign do_return = cmd_i.commit && (func_q == FUNC_RETURN) && !reject;

  always_ff @(posedge clk_i) begin
    rd_q     <= ring_q[head_q];
    rd_vld_q <= vld_q[head_q];
    if (do_return) ring_q[tail_q] <= slot_q[PTR_W-1:0];
    if (cmd_i.capture) begin
      func_q <= func_i;
      slot_q <= slot_index_i;
    end
    if (cmd_i.commit) begin
      if (func_q == FUNC_RENT) begin
        status_q <= (total_q == '0) ? STAT_EMPTY : STAT_GRANTED;
        grant_q  <= (total_q == '0) ? '0 : head_slot;
        count_q  <= (total_q == '0) ? total_q : total_q - CNT_W'(1);
      end else begin
        status_q <= reject ? STAT_REJECTED : STAT_RETURNED;
        grant_q  <= '0;
        count_q  <= reject ? total_q : total_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      total_q <= CNT_W'(SLOTS);
      pool_q  <= CNT_W'(SLOTS);
    end else if (cfg_we_i) begin
      vld_q   <= '0;
      head_q  <= '0;
      tail_q  <= (pool_d == CNT_W'(SLOTS)) ? '0 : pool_d[PTR_W-1:0];
      total_q <= pool_d;
      pool_q  <= pool_d;
    end else begin
      if (do_rent) begin
        head_q  <= ptr_next(head_q);
        total_q <= total_q - CNT_W'(1);
      end
      if (do_return) begin
        vld_q[tail_q] <= 1'b1;
        tail_q        <= ptr_next(tail_q);
        total_q       <= total_q + CNT_W'(1);
      end
    end
  end

  assign status_o       = status_q;
  assign granted_slot_o = grant_q;
  assign free_count_o   = count_q;

`ifndef ASSERT_OFF
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= pool_q)
    else $error("free total above pool size");
  a_pool_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pool_q >= CNT_W'(1)) && (pool_q <= CNT_W'(SLOTS)))
    else $error("pool size out of range");
  a_ring_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    PTR_W'(tail_q - head_q) == total_q[PTR_W-1:0])
    else $error("ring pointers disagree with free total");
`endif

endmodule

// ----- hw/rtl/free_slot_pool_allocator.sv -----
// channel  dir  handshake       payload
// req      in   valid / ready   func, slot_index
// rsp      out  valid / ready   status, granted_slot, free_count
// cfg      in   cfg_we_i        cfg_data_i (pool_count)
//
// each item is handled in order: first the free ring is read at the head pointer into its
// output register, then pointers, ring and the result register are updated.
// after reset the pool holds all slots in order; a pool_count write refills it at once.
// a new item is taken while the previous result still waits; the update stalls
// only while the result register is full and not being taken.
module free_slot_pool_allocator
  import fspa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  fspa_req_if.sink         req,
  fspa_rsp_if.source       rsp,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_data_i
);

  cmd_t cmd;

  fspa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_ready_o  (req.ready),
    .out_valid_o (rsp.valid),
    .out_ready_i (rsp.ready),
    .cmd_o       (cmd)
  );

  fspa_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .func_i         (req.func),
    .slot_index_i   (req.slot_index),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .status_o       (rsp.status),
    .granted_slot_o (rsp.granted_slot),
    .free_count_o   (rsp.free_count)
  );

endmodule

// ----- sim/fspa_alloc_checker.sv -----
module fspa_alloc_checker
  import fspa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  fspa_req_if              req,
  fspa_rsp_if              rsp,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_data_i,
  output int               pending_o,
  output int               fail_count_o,
  output int               granted_o,
  output int               empty_o,
  output int               returned_o,
  output int               rejected_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    status_e          status;
    logic [PTR_W-1:0] slot;
    logic [CNT_W-1:0] free_cnt;
  } alloc_result_t;

  // local copy of the free list
  logic [PTR_W-1:0] avail_ring [SLOTS];
  logic [PTR_W-1:0] take_ptr;
  logic [PTR_W-1:0] put_ptr;
  logic [CNT_W-1:0] free_slots;
  logic [CNT_W-1:0] pool_cnt;

  alloc_result_t expected_results_q [$];
  int            results_checked;

  initial begin
    pending_o       = 0;
    fail_count_o    = 0;
    granted_o       = 0;
    empty_o         = 0;
    returned_o      = 0;
    rejected_o      = 0;
    results_checked = 0;
  end

  task automatic refill_pool(input logic [CNT_W-1:0] value);
    logic [CNT_W-1:0] n;
    n = value;
    if (n == '0) n = CNT_W'(1);
    if (n > CNT_W'(SLOTS)) n = CNT_W'(SLOTS);
    pool_cnt = n;
    for (int i = 0; i < SLOTS; i++) avail_ring[i] = PTR_W'(i);
    take_ptr   = '0;
    put_ptr    = n[PTR_W-1:0];
    free_slots = n;
  endtask

  task automatic serve_request(input func_e func, input logic [IDX_W-1:0] slot_index);
    alloc_result_t r;
    r.slot = '0;
    if (func == FUNC_RENT) begin
      if (free_slots == '0) begin
        r.status = STAT_EMPTY;
      end else begin
        r.slot     = avail_ring[take_ptr];
        take_ptr   = take_ptr + PTR_W'(1);
        free_slots = free_slots - CNT_W'(1);
        r.status   = STAT_GRANTED;
      end
    end else begin
      // foreign slot, or the list is already full
      if (slot_index >= pool_cnt || free_slots >= pool_cnt) begin
        r.status = STAT_REJECTED;
      end else begin
        avail_ring[put_ptr] = slot_index[PTR_W-1:0];
        put_ptr             = put_ptr + PTR_W'(1);
        free_slots          = free_slots + CNT_W'(1);
        r.status            = STAT_RETURNED;
      end
    end
    r.free_cnt = free_slots;
    expected_results_q.push_back(r);
  endtask

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("%t: result %0d: %s got %0d, expected %0d", $realtime, results_checked,
             field, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i) begin
    alloc_result_t want;
    if (!rst_ni) begin
      refill_pool(CNT_W'(SLOTS));
      expected_results_q.delete();
    end else begin
      if (cfg_we_i) refill_pool(cfg_data_i);
      if (rsp.valid && rsp.ready) begin
        if (expected_results_q.size() == 0) begin
          report_mismatch("unexpected item, status", int'(rsp.status), -1);
        end else begin
          want = expected_results_q.pop_front();
          if (rsp.status !== want.status)
            report_mismatch("status", int'(rsp.status), int'(want.status));
          if (rsp.granted_slot !== want.slot)
            report_mismatch("granted_slot", int'(rsp.granted_slot), int'(want.slot));
          if (rsp.free_count !== want.free_cnt)
            report_mismatch("free_count", int'(rsp.free_count), int'(want.free_cnt));
          case (want.status)
            STAT_GRANTED:  granted_o++;
            STAT_EMPTY:    empty_o++;
            STAT_RETURNED: returned_o++;
            default:       rejected_o++;
          endcase
        end
        results_checked++;
      end
      if (req.valid && req.ready) serve_request(req.func, req.slot_index);
    end
    pending_o = expected_results_q.size();
  end

  final begin
    if (expected_results_q.size() != 0)
      $display("%0d expected results never arrived", expected_results_q.size());
  end

endmodule

// ----- sim/tb_free_slot_pool_allocator.sv -----
module tb_free_slot_pool_allocator
  import fspa_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int PHASE_ITEMS = 195;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CNT_W-1:0] cfg_data_i;

  fspa_req_if req_ch ();
  fspa_rsp_if rsp_ch ();

  int pending;
  int fail_count;
  int n_granted;
  int n_empty;
  int n_returned;
  int n_rejected;

  int cycle_count    = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int items_sent     = 0;
  int directed_items = 0;
  int pool_writes    = 0;
  int pool_now       = SLOTS;

  free_slot_pool_allocator u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  fspa_alloc_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req          (req_ch),
    .rsp          (rsp_ch),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .pending_o    (pending),
    .fail_count_o (fail_count),
    .granted_o    (n_granted),
    .empty_o      (n_empty),
    .returned_o   (n_returned),
    .rejected_o   (n_rejected)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles", cycle_count);
    $display("** free_slot_pool_allocator: FAILED **");
    $finish;
  end

  // response side back-pressure
  always @(posedge clk_i) begin
    rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_request(input func_e func, input logic [IDX_W-1:0] slot_index);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    req_ch.valid      <= 1'b1;
    req_ch.func       <= func;
    req_ch.slot_index <= slot_index;
    do @(posedge clk_i); while (!req_ch.ready);
    items_sent++;
  endtask

  task automatic drain;
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic set_pool_count(input logic [CNT_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pool_writes++;
    pool_now = (value == '0) ? 1 : (value > CNT_W'(SLOTS)) ? SLOTS : int'(value);
  endtask

  initial begin
    int               seg_len;
    int               rent_pct;
    logic [CNT_W-1:0] pool_val;
    logic [IDX_W-1:0] slot;

    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_data_i        = '0;
    req_ch.valid      = 1'b0;
    req_ch.func       = FUNC_RENT;
    req_ch.slot_index = '0;
    rsp_ch.ready      = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // full pool straight out of reset
    send_request(FUNC_RENT, '0);
    send_request(FUNC_RENT, 7'd127);
    send_request(FUNC_RETURN, 7'd127);
    send_request(FUNC_RETURN, 7'd64);
    send_request(FUNC_RETURN, 7'd0);
    // slot 63 was never rented, still taken and fills the list
    send_request(FUNC_RETURN, 7'd63);
    send_request(FUNC_RETURN, 7'd5);
    drain();

    set_pool_count(7'd1);
    send_request(FUNC_RENT, '0);
    send_request(FUNC_RENT, '0);
    send_request(FUNC_RETURN, 7'd0);
    send_request(FUNC_RETURN, 7'd0);
    send_request(FUNC_RETURN, 7'd1);
    send_request(FUNC_RENT, 7'd85);
    drain();

    // zero is clamped to one slot
    set_pool_count(7'd0);
    send_request(FUNC_RENT, '0);
    send_request(FUNC_RENT, '0);
    drain();

    // oversize counts are clamped to the whole pool
    set_pool_count(7'd127);
    send_request(FUNC_RENT, '0);
    drain();
    set_pool_count(7'd65);

    set_pool_count(7'd2);
    send_request(FUNC_RENT, '0);
    send_request(FUNC_RENT, '0);
    send_request(FUNC_RENT, '0);
    send_request(FUNC_RETURN, 7'd1);
    send_request(FUNC_RETURN, 7'd0);
    send_request(FUNC_RETURN, 7'd1);
    drain();
    directed_items = items_sent;

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 18;
          recv_idle_pct = 72;
        end
        1: begin
          send_idle_pct = 72;
          recv_idle_pct = 18;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      while (items_sent < directed_items + (ph + 1) * PHASE_ITEMS) begin
        case ($urandom_range(9))
          0: pool_val = 7'd0;
          1: pool_val = 7'd1;
          2: pool_val = 7'd2;
          3: pool_val = 7'd64;
          4: pool_val = 7'd64;
          5: pool_val = 7'd127;
          default: pool_val = CNT_W'($urandom_range(0, 127));
        endcase
        set_pool_count(pool_val);
        seg_len  = $urandom_range(20, 100);
        rent_pct = $urandom_range(20, 80);
        for (int i = 0; i < seg_len; i++) begin
          if ($urandom_range(99) < rent_pct) begin
            send_request(FUNC_RENT, IDX_W'($urandom_range(0, 127)));
          end else begin
            // mostly slots of the pool, some foreign ones
            if ($urandom_range(99) < 85) slot = IDX_W'($urandom_range(0, pool_now - 1));
            else slot = IDX_W'($urandom_range(0, 127));
            send_request(FUNC_RETURN, slot);
          end
        end
        drain();
      end
    end

    repeat (10) @(posedge clk_i);
    $display("sent %0d requests (%0d directed) over %0d pool_count writes and 3 idle mixes",
             items_sent, directed_items, pool_writes);
    $display("results: %0d granted, %0d empty, %0d returned, %0d rejected",
             n_granted, n_empty, n_returned, n_rejected);
    if (fail_count == 0 && pending == 0) begin
      $display("** free_slot_pool_allocator: PASSED **");
    end else begin
      $display("** free_slot_pool_allocator: FAILED **");
    end
    $finish;
  end

endmodule
